[rtl/assert_macros.svh]
// Assertion macros shared by the voxel ray traversal RTL.
// Needs nothing else; included by the modules that check their own logic.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a condition at every clock edge outside reset.
`define ASSERT_ALWAYS(lbl, clk, rst_n, cond, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond)) else $error(msg);

// Check that an antecedent implies a consequent in the same cycle.
`define ASSERT_IMPLIES(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

// Check that an antecedent implies a consequent in the following cycle.
`define ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

[rtl/vrt_pkg.sv]
// Shared widths, codes and queue entry type of the voxel ray traversal block.
// No dependencies; every other file but assert_macros.svh imports it.
`timescale 1ns / 1ps

package vrt_pkg;

  // Field widths fixed by the channel format
  localparam int COORD_W = 18;
  localparam int X_W     = 4;
  localparam int Y_W     = 8;
  localparam int Z_W     = 4;
  localparam int FACE_W  = 2;
  localparam int N_W     = COORD_W + 1;

  // Parameter defaults
  localparam int MAP_SIDE_DEF      = 16;
  localparam int COLUMN_HEIGHT_DEF = 256;
  localparam int FRAC_BITS_DEF     = 8;
  localparam int MAX_STEPS_DEF     = 512;
  localparam int QUEUE_DEPTH_DEF   = 2;

  // Function codes
  localparam logic FUNC_WRITE = 1'b0;
  localparam logic FUNC_CAST  = 1'b1;

  // Axis codes
  localparam logic [1:0] AXIS_X = 2'd0;
  localparam logic [1:0] AXIS_Y = 2'd1;
  localparam logic [1:0] AXIS_Z = 2'd2;

  // Face offsets
  localparam logic signed [FACE_W-1:0] FACE_POS = 2'sb01;
  localparam logic signed [FACE_W-1:0] FACE_NEG = 2'sb11;

  // Per-axis ray setup computed by the front end
  typedef struct packed {
    logic                     act;
    logic                     neg;
    logic signed [COORD_W:0]  vox;
    logic [N_W-1:0]           n;
    logic [COORD_W-1:0]       ad;
  } axis_t;

  // Classified transaction held in the queue
  typedef struct packed {
    logic           is_cast;
    logic           wr_ok;
    logic [X_W-1:0] x;
    logic [Y_W-1:0] y;
    logic [Z_W-1:0] z;
    logic           solid;
    axis_t [2:0]    ax;
  } entry_t;

endpackage

[rtl/vrt_if.sv]
// Request and response channel interfaces of the voxel ray traversal block.
// Depends on vrt_pkg for field widths.
`timescale 1ns / 1ps

interface vrt_req_if import vrt_pkg::*; ();
  logic                      valid;
  logic                      ready;
  logic                      func;
  logic [X_W-1:0]            voxel_x;
  logic [Y_W-1:0]            voxel_y;
  logic [Z_W-1:0]            voxel_z;
  logic                      solid_bit;
  logic signed [COORD_W-1:0] start_x;
  logic signed [COORD_W-1:0] start_y;
  logic signed [COORD_W-1:0] start_z;
  logic signed [COORD_W-1:0] end_x;
  logic signed [COORD_W-1:0] end_y;
  logic signed [COORD_W-1:0] end_z;

  modport source (
    output valid, func, voxel_x, voxel_y, voxel_z, solid_bit,
           start_x, start_y, start_z, end_x, end_y, end_z,
    input  ready
  );
  modport sink (
    input  valid, func, voxel_x, voxel_y, voxel_z, solid_bit,
           start_x, start_y, start_z, end_x, end_y, end_z,
    output ready
  );
endinterface

interface vrt_rsp_if import vrt_pkg::*; ();
  logic                     valid;
  logic                     ready;
  logic                     hit;
  logic [X_W-1:0]           hit_x;
  logic [Y_W-1:0]           hit_y;
  logic [Z_W-1:0]           hit_z;
  logic signed [FACE_W-1:0] face_x;
  logic signed [FACE_W-1:0] face_y;
  logic signed [FACE_W-1:0] face_z;

  modport source (
    output valid, hit, hit_x, hit_y, hit_z, face_x, face_y, face_z,
    input  ready
  );
  modport sink (
    input  valid, hit, hit_x, hit_y, hit_z, face_x, face_y, face_z,
    output ready
  );
endinterface

[rtl/vrt_front.sv]
// Front end: accepts request transactions and classifies them into queue entries.
// Depends on vrt_pkg and vrt_req_if.
`timescale 1ns / 1ps

module vrt_front import vrt_pkg::*; #(
  parameter int MAP_SIDE      = MAP_SIDE_DEF,
  parameter int COLUMN_HEIGHT = COLUMN_HEIGHT_DEF,
  parameter int FRAC_BITS     = FRAC_BITS_DEF
) (
  vrt_req_if.sink req_i,
  input  logic    clr_busy_i,
  output logic    push_valid_o,
  input  logic    push_ready_i,
  output entry_t  push_data_o
);

  localparam logic signed [COORD_W:0] HALF = (COORD_W+1)'(1) <<< (FRAC_BITS - 1);
  localparam logic [N_W-1:0]          ONE  = N_W'(1) << FRAC_BITS;

  logic signed [COORD_W-1:0] st [3];
  logic signed [COORD_W-1:0] en [3];
  logic signed [COORD_W:0]   s  [3];
  logic signed [COORD_W:0]   e  [3];
  logic signed [COORD_W:0]   d  [3];
  logic [N_W-1:0]            fr [3];

  // Hold requests while the map clears or the queue is full
  assign req_i.ready  = push_ready_i && !clr_busy_i;
  assign push_valid_o = req_i.valid && !clr_busy_i;

  assign st[0] = req_i.start_x;
  assign st[1] = req_i.start_y;
  assign st[2] = req_i.start_z;
  assign en[0] = req_i.end_x;
  assign en[1] = req_i.end_y;
  assign en[2] = req_i.end_z;

  // Classify the transaction and set up each ray axis
  always_comb begin
    push_data_o.is_cast = (req_i.func == FUNC_CAST);
    push_data_o.wr_ok   = (32'(req_i.voxel_x) < MAP_SIDE) &&
                          (32'(req_i.voxel_y) < COLUMN_HEIGHT) &&
                          (32'(req_i.voxel_z) < MAP_SIDE);
    push_data_o.x       = req_i.voxel_x;
    push_data_o.y       = req_i.voxel_y;
    push_data_o.z       = req_i.voxel_z;
    push_data_o.solid   = req_i.solid_bit;
    for (int a = 0; a < 3; a++) begin
      s[a]  = (COORD_W+1)'(st[a]) + HALF;
      e[a]  = (COORD_W+1)'(en[a]) + HALF;
      d[a]  = e[a] - s[a];
      fr[a] = N_W'(s[a][FRAC_BITS-1:0]);
      push_data_o.ax[a].vox  = s[a] >>> FRAC_BITS;
      push_data_o.ax[a].act  = (d[a] != '0);
      push_data_o.ax[a].neg  = d[a][COORD_W];
      if (d[a] == '0) begin
        push_data_o.ax[a].n  = '0;
        push_data_o.ax[a].ad = '0;
      end else if (d[a][COORD_W]) begin
        push_data_o.ax[a].n  = fr[a];
        push_data_o.ax[a].ad = COORD_W'(-d[a]);
      end else begin
        push_data_o.ax[a].n  = ONE - fr[a];
        push_data_o.ax[a].ad = COORD_W'(d[a]);
      end
    end
  end

endmodule

[rtl/vrt_queue.sv]
// Small FIFO that decouples the front end from the traversal engine.
// Depends on vrt_pkg for the entry type and on assert_macros.svh.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module vrt_queue import vrt_pkg::*; #(
  parameter int DEPTH = QUEUE_DEPTH_DEF
) (
  input  logic   clk_i,
  input  logic   rst_ni,
  input  logic   push_valid_i,
  output logic   push_ready_o,
  input  entry_t push_data_i,
  output logic   pop_valid_o,
  input  logic   pop_ready_i,
  output entry_t pop_data_o
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  entry_t           fifo_q [DEPTH];
  logic [PTR_W-1:0] wr_ptr_q, rd_ptr_q;
  logic [CNT_W-1:0] cnt_q;
  logic             push, pop;

  assign push_ready_o = (cnt_q != CNT_W'(DEPTH));
  assign pop_valid_o  = (cnt_q != '0);
  assign push         = push_valid_i && push_ready_o;
  assign pop          = pop_valid_o && pop_ready_i;
  assign pop_data_o   = fifo_q[rd_ptr_q];

  // Store entries
  always_ff @(posedge clk_i) begin
    if (push) begin
      fifo_q[wr_ptr_q] <= push_data_i;
    end
  end

  // Advance pointers and count
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      if (push) begin
        wr_ptr_q <= (wr_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_q + PTR_W'(1);
      end
      if (pop) begin
        rd_ptr_q <= (rd_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_q + PTR_W'(1);
      end
      if (push && !pop) begin
        cnt_q <= cnt_q + CNT_W'(1);
      end else if (pop && !push) begin
        cnt_q <= cnt_q - CNT_W'(1);
      end
    end
  end

  `ASSERT_ALWAYS(a_cnt_bound, clk_i, rst_ni, cnt_q <= CNT_W'(DEPTH), "queue count overflow")
  `ASSERT_NEXT(a_cnt_grow, clk_i, rst_ni, push && !pop, cnt_q == $past(cnt_q) + 1'b1, "queue count lost a push")

endmodule

[rtl/vrt_walk.sv]
// Back end: voxel map memory with clearing pass, ray setup and grid walk.
// Depends on vrt_pkg, vrt_rsp_if and assert_macros.svh.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module vrt_walk import vrt_pkg::*; #(
  parameter int MAP_SIDE      = MAP_SIDE_DEF,
  parameter int COLUMN_HEIGHT = COLUMN_HEIGHT_DEF,
  parameter int FRAC_BITS     = FRAC_BITS_DEF,
  parameter int MAX_STEPS     = MAX_STEPS_DEF
) (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     pop_valid_i,
  output logic     pop_ready_o,
  input  entry_t   pop_data_i,
  output logic     clr_busy_o,
  vrt_rsp_if.source rsp_o
);

  localparam int CX_W   = $clog2(MAP_SIDE);
  localparam int CY_W   = $clog2(COLUMN_HEIGHT);
  localparam int ROWS   = MAP_SIDE * COLUMN_HEIGHT;
  localparam int ROW_W  = $clog2(ROWS);
  localparam int CW_A   = COORD_W - FRAC_BITS;
  localparam int CW_B   = $clog2(MAX_STEPS);
  localparam int CW_AB  = (CW_A > CW_B) ? CW_A : CW_B;
  localparam int CW_C   = (CX_W > CY_W) ? CX_W : CY_W;
  localparam int CELL_W = ((CW_AB > CW_C) ? CW_AB : CW_C) + 2;
  localparam int STEP_W = $clog2(MAX_STEPS + 1);
  localparam int P_W    = N_W + COORD_W;
  localparam int NPAIR  = 6;
  localparam logic [N_W-1:0] ONE = N_W'(1) << FRAC_BITS;

  // Cross product slots: slot k holds n[PA[k]] * ad[PB[k]]
  localparam logic [1:0] PA [NPAIR] = '{AXIS_X, AXIS_Y, AXIS_X, AXIS_Z, AXIS_Y, AXIS_Z};
  localparam logic [1:0] PB [NPAIR] = '{AXIS_Y, AXIS_X, AXIS_Z, AXIS_X, AXIS_Z, AXIS_Y};

  localparam logic [2:0] ST_IDLE  = 3'd0;
  localparam logic [2:0] ST_SETUP = 3'd1;
  localparam logic [2:0] ST_STEP  = 3'd2;
  localparam logic [2:0] ST_TEST  = 3'd3;
  localparam logic [2:0] ST_DONE  = 3'd4;

  logic [2:0]               state_q, state_d;
  logic                     clr_busy_q;
  logic [ROW_W-1:0]         clr_cnt_q;
  logic [2:0]               mul_idx_q;
  logic [STEP_W-1:0]        step_cnt_q;
  logic                     out_vld_q;

  logic [MAP_SIDE-1:0]      mem_q [ROWS];
  logic [MAP_SIDE-1:0]      mem_rd_q;

  logic signed [CELL_W-1:0] cell_q [3];
  logic [N_W-1:0]           n_q    [3];
  logic [COORD_W-1:0]       ad_q   [3];
  logic [2:0]               act_q, neg_q;
  logic [P_W-1:0]           p_q    [NPAIR];
  logic [1:0]               ax_q;
  logic                     in_map_q;
  logic [CX_W-1:0]          col_q;

  logic                     res_hit_q;
  logic [X_W-1:0]           res_x_q;
  logic [Y_W-1:0]           res_y_q;
  logic [Z_W-1:0]           res_z_q;
  logic signed [FACE_W-1:0] res_f_q [3];

  logic                     out_hit_q;
  logic [X_W-1:0]           out_x_q;
  logic [Y_W-1:0]           out_y_q;
  logic [Z_W-1:0]           out_z_q;
  logic signed [FACE_W-1:0] out_f_q [3];

  logic                     take, wr_en, rd_en, any_act, out_free;
  logic [ROW_W-1:0]         wr_row, rd_row;
  logic [CX_W-1:0]          wr_col;
  logic                     e01, e02, e12, past_end, in_map_nx, solid;
  logic [1:0]               ax;
  logic signed [CELL_W-1:0] cell_nx [3];
  logic [P_W-1:0]           prod;

  assign clr_busy_o  = clr_busy_q;
  assign pop_ready_o = (state_q == ST_IDLE) && !clr_busy_q;
  assign take        = pop_valid_i && pop_ready_o;
  assign any_act     = pop_data_i.ax[0].act || pop_data_i.ax[1].act || pop_data_i.ax[2].act;
  assign out_free    = !out_vld_q || rsp_o.ready;

  // Voxel write address from a queued write transaction
  assign wr_en  = take && !pop_data_i.is_cast && pop_data_i.wr_ok;
  assign wr_row = ROW_W'(pop_data_i.y) + ROW_W'(COLUMN_HEIGHT) * ROW_W'(pop_data_i.z);
  assign wr_col = CX_W'(pop_data_i.x);

  // Pick the axis with the earliest boundary; ties go to z, then y
  always_comb begin
    e01 = act_q[0] && (!act_q[1] || (p_q[0] < p_q[1]));
    e02 = act_q[0] && (!act_q[2] || (p_q[2] < p_q[3]));
    e12 = act_q[1] && (!act_q[2] || (p_q[4] < p_q[5]));
    if (e01) begin
      ax = e02 ? AXIS_X : AXIS_Z;
    end else begin
      ax = e12 ? AXIS_Y : AXIS_Z;
    end
    past_end = n_q[ax] > N_W'(ad_q[ax]);
    for (int a = 0; a < 3; a++) begin
      cell_nx[a] = cell_q[a];
    end
    cell_nx[ax] = neg_q[ax] ? cell_q[ax] - CELL_W'(1) : cell_q[ax] + CELL_W'(1);
    in_map_nx = (cell_nx[0] >= 0) && (cell_nx[0] < MAP_SIDE) &&
                (cell_nx[1] >= 0) && (cell_nx[1] < COLUMN_HEIGHT) &&
                (cell_nx[2] >= 0) && (cell_nx[2] < MAP_SIDE);
    rd_row = ROW_W'(cell_nx[1][CY_W-1:0]) +
             ROW_W'(COLUMN_HEIGHT) * ROW_W'(cell_nx[2][CX_W-1:0]);
  end

  assign rd_en = (state_q == ST_STEP) && !past_end;
  assign solid = in_map_q && mem_rd_q[col_q];
  assign prod  = P_W'(n_q[PA[mul_idx_q]]) * P_W'(ad_q[PB[mul_idx_q]]);

  // Next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: begin
        if (take && pop_data_i.is_cast) begin
          state_d = any_act ? ST_SETUP : ST_DONE;
        end
      end
      ST_SETUP: begin
        if (mul_idx_q == 3'(NPAIR - 1)) begin
          state_d = ST_STEP;
        end
      end
      ST_STEP: begin
        state_d = past_end ? ST_DONE : ST_TEST;
      end
      ST_TEST: begin
        if (solid || (step_cnt_q == STEP_W'(MAX_STEPS))) begin
          state_d = ST_DONE;
        end else begin
          state_d = ST_STEP;
        end
      end
      ST_DONE: begin
        if (out_free) begin
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // Map memory: clearing pass, voxel writes, registered row reads
  always_ff @(posedge clk_i) begin
    if (clr_busy_q) begin
      mem_q[clr_cnt_q] <= '0;
    end else if (wr_en) begin
      mem_q[wr_row][wr_col] <= pop_data_i.solid;
    end
    if (rd_en) begin
      mem_rd_q <= mem_q[rd_row];
    end
  end

  // Control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= ST_IDLE;
      clr_busy_q <= 1'b1;
      clr_cnt_q  <= '0;
      mul_idx_q  <= '0;
      step_cnt_q <= '0;
      out_vld_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      if (clr_busy_q) begin
        clr_cnt_q <= clr_cnt_q + ROW_W'(1);
        if (clr_cnt_q == ROW_W'(ROWS - 1)) begin
          clr_busy_q <= 1'b0;
        end
      end
      if (state_q == ST_SETUP) begin
        mul_idx_q <= (mul_idx_q == 3'(NPAIR - 1)) ? '0 : mul_idx_q + 3'd1;
      end
      if (state_q == ST_IDLE) begin
        step_cnt_q <= '0;
      end else if (rd_en) begin
        step_cnt_q <= step_cnt_q + STEP_W'(1);
      end
      if (state_q == ST_DONE && out_free) begin
        out_vld_q <= 1'b1;
      end else if (rsp_o.ready) begin
        out_vld_q <= 1'b0;
      end
    end
  end

  // Ray registers, cross products and results
  always_ff @(posedge clk_i) begin
    case (state_q)
      ST_IDLE: begin
        if (take && pop_data_i.is_cast) begin
          for (int a = 0; a < 3; a++) begin
            cell_q[a] <= CELL_W'(pop_data_i.ax[a].vox);
            n_q[a]    <= pop_data_i.ax[a].n;
            ad_q[a]   <= pop_data_i.ax[a].ad;
            act_q[a]  <= pop_data_i.ax[a].act;
            neg_q[a]  <= pop_data_i.ax[a].neg;
            res_f_q[a] <= '0;
          end
          res_hit_q <= 1'b0;
          res_x_q   <= '0;
          res_y_q   <= '0;
          res_z_q   <= '0;
        end
      end
      ST_SETUP: begin
        p_q[mul_idx_q] <= prod;
      end
      ST_STEP: begin
        if (!past_end) begin
          n_q[ax] <= n_q[ax] + ONE;
          for (int k = 0; k < NPAIR; k++) begin
            if (PA[k] == ax) begin
              p_q[k] <= p_q[k] + (P_W'(ad_q[PB[k]]) << FRAC_BITS);
            end
          end
          for (int a = 0; a < 3; a++) begin
            cell_q[a] <= cell_nx[a];
          end
          ax_q     <= ax;
          in_map_q <= in_map_nx;
          col_q    <= cell_nx[0][CX_W-1:0];
        end
      end
      ST_TEST: begin
        if (solid) begin
          res_hit_q <= 1'b1;
          res_x_q   <= X_W'(cell_q[0]);
          res_y_q   <= Y_W'(cell_q[1]);
          res_z_q   <= Z_W'(cell_q[2]);
          for (int a = 0; a < 3; a++) begin
            if (2'(a) == ax_q) begin
              res_f_q[a] <= neg_q[a] ? FACE_POS : FACE_NEG;
            end else begin
              res_f_q[a] <= '0;
            end
          end
        end
      end
      ST_DONE: begin
        if (out_free) begin
          out_hit_q <= res_hit_q;
          out_x_q   <= res_x_q;
          out_y_q   <= res_y_q;
          out_z_q   <= res_z_q;
          for (int a = 0; a < 3; a++) begin
            out_f_q[a] <= res_f_q[a];
          end
        end
      end
      default: ;
    endcase
  end

  // Drive the response channel
  assign rsp_o.valid  = out_vld_q;
  assign rsp_o.hit    = out_hit_q;
  assign rsp_o.hit_x  = out_x_q;
  assign rsp_o.hit_y  = out_y_q;
  assign rsp_o.hit_z  = out_z_q;
  assign rsp_o.face_x = out_f_q[0];
  assign rsp_o.face_y = out_f_q[1];
  assign rsp_o.face_z = out_f_q[2];

  `ASSERT_IMPLIES(a_test_after_step, clk_i, rst_ni, state_q == ST_TEST, $past(state_q) == ST_STEP, "voxel test without a step")
  `ASSERT_ALWAYS(a_step_limit, clk_i, rst_ni, step_cnt_q <= STEP_W'(MAX_STEPS), "step count past limit")
  `ASSERT_IMPLIES(a_clear_idle, clk_i, rst_ni, clr_busy_q, (state_q == ST_IDLE) && !wr_en, "work during map clear")

endmodule

[rtl/voxel_ray_traversal_core.sv]
// Top level of the voxel ray traversal block: front end, queue, walk engine.
// Depends on vrt_pkg, vrt_if, vrt_front, vrt_queue and vrt_walk.
`timescale 1ns / 1ps

// Voxel column ray caster.
// req_i carries one transaction per valid/ready handshake. func = write sets
// or clears one voxel of the solid map and gives no response. func = cast walks
// a ray from start to end (signed fixed point) and returns one response on
// rsp_o: the first solid voxel entered and the face it was entered by, or a
// miss with all fields zero.
// A write waits in the queue and, if in range, reaches the map when the
// idle engine takes it. A cast first forms the six setup products, then
// alternates a step with a registered map read and a voxel test until it
// finds a solid voxel, passes the end point or reaches MAX_STEPS steps;
// the result then goes out through the output register on rsp_o.
// Casts are handled one at a time; the queue keeps taking transactions while
// a cast is walked.
// Reset: the map is cleared row by row, MAP_SIDE*COLUMN_HEIGHT rows
// (4096 with the defaults); req_i.ready stays low until it is done.
// A stalled rsp_o holds its result; the engine then waits, and req_i stalls
// once the queue fills.
module voxel_ray_traversal_core import vrt_pkg::*; #(
  parameter int MAP_SIDE      = MAP_SIDE_DEF,
  parameter int COLUMN_HEIGHT = COLUMN_HEIGHT_DEF,
  parameter int FRAC_BITS     = FRAC_BITS_DEF,
  parameter int MAX_STEPS     = MAX_STEPS_DEF,
  parameter int QUEUE_DEPTH   = QUEUE_DEPTH_DEF
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  vrt_req_if.sink   req_i,
  vrt_rsp_if.source rsp_o
);

  logic   clr_busy;
  logic   push_valid, push_ready, pop_valid, pop_ready;
  entry_t push_data, pop_data;

  // Classify incoming transactions
  vrt_front #(
    .MAP_SIDE      (MAP_SIDE),
    .COLUMN_HEIGHT (COLUMN_HEIGHT),
    .FRAC_BITS     (FRAC_BITS)
  ) u_front (
    .req_i        (req_i),
    .clr_busy_i   (clr_busy),
    .push_valid_o (push_valid),
    .push_ready_i (push_ready),
    .push_data_o  (push_data)
  );

  // Decouple front and back
  vrt_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_valid_i (push_valid),
    .push_ready_o (push_ready),
    .push_data_i  (push_data),
    .pop_valid_o  (pop_valid),
    .pop_ready_i  (pop_ready),
    .pop_data_o   (pop_data)
  );

  // Execute writes and walk rays
  vrt_walk #(
    .MAP_SIDE      (MAP_SIDE),
    .COLUMN_HEIGHT (COLUMN_HEIGHT),
    .FRAC_BITS     (FRAC_BITS),
    .MAX_STEPS     (MAX_STEPS)
  ) u_walk (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .pop_valid_i (pop_valid),
    .pop_ready_o (pop_ready),
    .pop_data_i  (pop_data),
    .clr_busy_o  (clr_busy),
    .rsp_o       (rsp_o)
  );

endmodule
